@@ src/rhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhc_pkg: shared types, constants and helpers for the rgb to hsl converter
// holds the divider word layout and the single restoring division step
// ---------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHAN_W = 8;
  localparam int NUM_W  = 2 * CHAN_W;
  localparam int QUO_W  = CHAN_W;
  localparam int HUE_W  = CHAN_W + 2;

  localparam int HUE_SIXTH_DEF     = 42;
  localparam int HUE_UNDEFINED_DEF = 0;
  localparam int SAT_SCALE_DEF     = 255;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    chan_t rem;
    chan_t low;
    chan_t quo;
    chan_t den;
  } div_lane_t;

  typedef struct packed {
    chan_t   light;
    logic    gray;
    logic    neg;
    sector_t sector;
  } side_t;

  typedef struct packed {
    div_lane_t sat;
    div_lane_t hue;
    side_t     side;
  } div_word_t;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic div_lane_t div_step(input div_lane_t a);
    logic [CHAN_W:0] tmp;
    logic [CHAN_W:0] dif;
    div_lane_t       r;
    tmp   = {a.rem, a.low[CHAN_W-1]};
    dif   = tmp - {1'b0, a.den};
    r     = a;
    r.low = {a.low[CHAN_W-2:0], 1'b0};
    if (tmp >= {1'b0, a.den}) begin
      r.rem = dif[CHAN_W-1:0];
      r.quo = {a.quo[CHAN_W-2:0], 1'b1};
    end else begin
      r.rem = tmp[CHAN_W-1:0];
      r.quo = {a.quo[CHAN_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/rhc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhc_front: channel extremes, sector choice and divider operands
// two register stages: max/min and signed difference, then products
// ---------------------------------------------------------------------------
module rhc_front #(
  parameter int HUE_SIXTH = rhc_pkg::HUE_SIXTH_DEF,
  parameter int SAT_SCALE = rhc_pkg::SAT_SCALE_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en_a,
  input  wire logic                    en_b,
  input  wire logic [rhc_pkg::CHAN_W-1:0] red_in,
  input  wire logic [rhc_pkg::CHAN_W-1:0] green_in,
  input  wire logic [rhc_pkg::CHAN_W-1:0] blue_in,
  output rhc_pkg::div_word_t           word
);

  localparam int CW = rhc_pkg::CHAN_W;
  localparam int NW = rhc_pkg::NUM_W;
  localparam logic [CW:0] CHAN_FULL = {1'b0, {CW{1'b1}}};
  localparam logic [CW:0] CHAN_TWICE = {{CW{1'b1}}, 1'b0};

  rhc_pkg::chan_t   hi_c, lo_c, mag_c;
  logic signed [CW:0] diff_c;
  rhc_pkg::sector_t sector_c;

  rhc_pkg::chan_t   span;
  logic [CW:0]      total;
  rhc_pkg::chan_t   mag;
  logic             neg;
  rhc_pkg::sector_t sector;

  logic [CW:0]      denom_c;
  logic [NW-1:0]    sat_num_c, hue_num_c;
  rhc_pkg::div_word_t word_c;

  always_comb begin
    hi_c = (red_in > green_in) ? red_in : green_in;
    lo_c = (red_in < green_in) ? red_in : green_in;
    if (blue_in > hi_c) hi_c = blue_in;
    if (blue_in < lo_c) lo_c = blue_in;
    priority if (red_in == hi_c) begin
      sector_c = rhc_pkg::SECT_RED;
      diff_c   = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
    end else if (green_in == hi_c) begin
      sector_c = rhc_pkg::SECT_GREEN;
      diff_c   = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
    end else begin
      sector_c = rhc_pkg::SECT_BLUE;
      diff_c   = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
    end
    mag_c = diff_c[CW] ? CW'(-diff_c) : diff_c[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      span   <= hi_c - lo_c;
      total  <= {1'b0, hi_c} + {1'b0, lo_c};
      mag    <= mag_c;
      neg    <= diff_c[CW];
      sector <= sector_c;
    end
  end

  always_comb begin
    denom_c   = (total > CHAN_FULL) ? (CHAN_TWICE - total) : total;
    sat_num_c = NW'(span) * NW'(SAT_SCALE);
    hue_num_c = NW'(mag) * NW'(HUE_SIXTH);
    word_c.sat.rem     = sat_num_c[NW-1:CW];
    word_c.sat.low     = sat_num_c[CW-1:0];
    word_c.sat.quo     = '0;
    word_c.sat.den     = denom_c[CW-1:0];
    word_c.hue.rem     = hue_num_c[NW-1:CW];
    word_c.hue.low     = hue_num_c[CW-1:0];
    word_c.hue.quo     = '0;
    word_c.hue.den     = span;
    word_c.side.light  = total[CW:1];
    word_c.side.gray   = (span == '0);
    word_c.side.neg    = neg;
    word_c.side.sector = sector;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      word <= word_c;
    end
  end

endmodule
`default_nettype wire

@@ src/rhc_div_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhc_div_step: one registered restoring division step
// advances the saturation and hue quotients by one bit each
// ---------------------------------------------------------------------------
module rhc_div_step (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire rhc_pkg::div_word_t d,
  output rhc_pkg::div_word_t      q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q.sat  <= rhc_pkg::div_step(d.sat);
      q.hue  <= rhc_pkg::div_step(d.hue);
      q.side <= d.side;
    end
  end

endmodule
`default_nettype wire

@@ src/rhc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhc_back: hue sign, sector offset and wrap, gray override
// also the output register of the block
// ---------------------------------------------------------------------------
module rhc_back #(
  parameter int HUE_SIXTH     = rhc_pkg::HUE_SIXTH_DEF,
  parameter int HUE_UNDEFINED = rhc_pkg::HUE_UNDEFINED_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire rhc_pkg::div_word_t         d,
  output logic [rhc_pkg::CHAN_W-1:0]      hue_out,
  output logic [rhc_pkg::CHAN_W-1:0]      sat_out,
  output logic [rhc_pkg::CHAN_W-1:0]      light_out
);

  localparam int CW = rhc_pkg::CHAN_W;
  localparam int HW = rhc_pkg::HUE_W;
  localparam logic signed [HW-1:0] HUE_THIRD  = HW'(2 * HUE_SIXTH);
  localparam logic signed [HW-1:0] HUE_TWO3   = HW'(4 * HUE_SIXTH);
  localparam logic signed [HW-1:0] HUE_CIRCLE = HW'(6 * HUE_SIXTH);

  logic signed [HW-1:0] quo_c, offset_c, hue_c;

  always_comb begin
    quo_c = $signed({2'b00, d.hue.quo});
    unique case (d.side.sector)
      rhc_pkg::SECT_RED:   offset_c = '0;
      rhc_pkg::SECT_GREEN: offset_c = HUE_THIRD;
      rhc_pkg::SECT_BLUE:  offset_c = HUE_TWO3;
      default:             offset_c = '0;
    endcase
    hue_c = (d.side.neg ? -quo_c : quo_c) + offset_c;
    if (hue_c < 0) hue_c = hue_c + HUE_CIRCLE;
    if (hue_c > HUE_CIRCLE) hue_c = hue_c - HUE_CIRCLE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      light_out <= d.side.light;
      if (d.side.gray) begin
        hue_out <= CW'(HUE_UNDEFINED);
        sat_out <= '0;
      end else begin
        hue_out <= hue_c[CW-1:0];
        sat_out <= d.sat.quo;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/rgb_to_hsl_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_to_hsl_converter: 8-bit rgb pixel to hue, saturation and lightness
// Pixel requests enter on red_in/green_in/blue_in with pix_valid/pix_stall;
// results leave on hue_out/sat_out/light_out with hsl_valid/hsl_stall.
// A request is taken at a clock edge with valid high and stall low.
// The pipe holds two operand stages, eight divider stages (one
// quotient bit each for both divisions) and the output stage.
// Throughput is one pixel per clock while hsl_stall is low; the divider is fully pipelined.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up behind a stalled result and new
// requests are still taken until every stage is full.
// pix_stall is high only when the whole pipe is full and hsl_stall is high.
// Synchronous reset empties the pipe; nothing is lost or repeated on stall.
// ---------------------------------------------------------------------------
module rgb_to_hsl_converter #(
  parameter int HUE_SIXTH     = rhc_pkg::HUE_SIXTH_DEF,
  parameter int HUE_UNDEFINED = rhc_pkg::HUE_UNDEFINED_DEF,
  parameter int SAT_SCALE     = rhc_pkg::SAT_SCALE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pix_valid,
  output logic                             pix_stall,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  red_in,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  green_in,
  input  wire logic [rhc_pkg::CHAN_W-1:0]  blue_in,
  output logic                             hsl_valid,
  input  wire logic                        hsl_stall,
  output logic [rhc_pkg::CHAN_W-1:0]       hue_out,
  output logic [rhc_pkg::CHAN_W-1:0]       sat_out,
  output logic [rhc_pkg::CHAN_W-1:0]       light_out
);

  localparam int QW = rhc_pkg::QUO_W;
  localparam int NS = QW + 3;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  rhc_pkg::div_word_t w [0:QW];

  always_comb begin
    rdy[NS] = !hsl_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= pix_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  rhc_front #(
    .HUE_SIXTH (HUE_SIXTH),
    .SAT_SCALE (SAT_SCALE)
  ) u_front (
    .clk      (clk),
    .en_a     (rdy[0]),
    .en_b     (rdy[1]),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .word     (w[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    rhc_div_step u_step (
      .clk (clk),
      .en  (rdy[k+2]),
      .d   (w[k]),
      .q   (w[k+1])
    );
  end

  rhc_back #(
    .HUE_SIXTH     (HUE_SIXTH),
    .HUE_UNDEFINED (HUE_UNDEFINED)
  ) u_back (
    .clk       (clk),
    .en        (rdy[NS-1]),
    .d         (w[QW]),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .light_out (light_out)
  );

  assign pix_stall = !rdy[0];
  assign hsl_valid = vld[NS-1];

endmodule
`default_nettype wire

@@ src/rhc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhc_checker: port level checks for the rgb to hsl converter
// attached to the top level by the bind at the end of this file
// ---------------------------------------------------------------------------
module rhc_checker #(
  parameter int HUE_SIXTH     = rhc_pkg::HUE_SIXTH_DEF,
  parameter int HUE_UNDEFINED = rhc_pkg::HUE_UNDEFINED_DEF,
  parameter int SAT_SCALE     = rhc_pkg::SAT_SCALE_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       pix_stall,
  input wire logic                       hsl_valid,
  input wire logic                       hsl_stall,
  input wire logic [rhc_pkg::CHAN_W-1:0] hue_out,
  input wire logic [rhc_pkg::CHAN_W-1:0] sat_out
);

  localparam int HW = rhc_pkg::HUE_W;
  localparam logic [HW-1:0] HUE_CIRCLE = HW'(6 * HUE_SIXTH);
  localparam logic [HW-1:0] HUE_UNDEF  = HW'(HUE_UNDEFINED);
  localparam logic [HW-1:0] SAT_TOP    = HW'(SAT_SCALE);

  // a result held back by the receiver stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && hsl_stall |=> hsl_valid && $stable(hue_out) && $stable(sat_out))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !hsl_valid)
    else $error("result shown straight after reset");

  // an open output never holds back the input side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !hsl_stall |-> !pix_stall)
    else $error("input stalled with output free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> ({2'b00, sat_out} <= SAT_TOP) &&
                  (({2'b00, hue_out} <= HUE_CIRCLE) || ({2'b00, hue_out} == HUE_UNDEF)))
    else $error("result out of range");

endmodule

bind rgb_to_hsl_converter rhc_checker #(
  .HUE_SIXTH     (HUE_SIXTH),
  .HUE_UNDEFINED (HUE_UNDEFINED),
  .SAT_SCALE     (SAT_SCALE)
) u_rhc_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .hsl_valid (hsl_valid),
  .hsl_stall (hsl_stall),
  .hue_out   (hue_out),
  .sat_out   (sat_out)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the rgb to hsl converter
// Pixel requests go in through a valid/stall handshake with random gaps;
// every taken request is converted by a local model of the hue, saturation
// and lightness arithmetic, and each result leaving the block is compared
// field by field with the oldest prediction. The receiver stalls at random,
// once holds off long enough to back the pipe up, and the sender once
// pauses until the pipe has drained.
// ---------------------------------------------------------------------------
module tb;

  typedef rhc_pkg::chan_t chan_t;

  localparam int HUE_SIXTH   = rhc_pkg::HUE_SIXTH_DEF;
  localparam int HUE_UNDEF   = rhc_pkg::HUE_UNDEFINED_DEF;
  localparam int SAT_SCALE   = rhc_pkg::SAT_SCALE_DEF;
  localparam int CHAN_FULL   = 2 ** rhc_pkg::CHAN_W - 1;
  localparam int LATENCY     = 11;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_GAP     = 17;

  typedef struct packed {
    chan_t hue;
    chan_t sat;
    chan_t light;
  } hsl_t;

  logic  clk;
  logic  rst;
  logic  pix_valid;
  logic  pix_stall;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  logic  hsl_valid;
  logic  hsl_stall;
  chan_t hue_out;
  chan_t sat_out;
  chan_t light_out;

  hsl_t hsl_expected[$];
  int   mismatches = 0;
  bit   sender_idle_on = 1'b0;
  bit   stall_on = 1'b0;
  int   hold_asks = 0;

  rgb_to_hsl_converter dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .light_out (light_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic hsl_t hsl_of_pixel(input chan_t r, input chan_t g, input chan_t b);
    int   red, grn, blu, hi, lo, total, span, denom, hue, sat;
    hsl_t res;
    red = r;
    grn = g;
    blu = b;
    hi = (red > grn) ? red : grn;
    lo = (red < grn) ? red : grn;
    if (blu > hi) hi = blu;
    if (blu < lo) lo = blu;
    total = hi + lo;
    span = hi - lo;
    res.light = chan_t'(total >> 1);
    if (span == 0) begin
      res.hue = chan_t'(HUE_UNDEF);
      res.sat = '0;
    end else begin
      denom = (total > CHAN_FULL) ? 2 * CHAN_FULL - total : total;
      sat = (span * SAT_SCALE) / denom;
      if (red == hi) begin
        hue = (HUE_SIXTH * (grn - blu)) / span;
      end else if (grn == hi) begin
        hue = (HUE_SIXTH * (blu - red)) / span + 2 * HUE_SIXTH;
      end else begin
        hue = (HUE_SIXTH * (red - grn)) / span + 4 * HUE_SIXTH;
      end
      if (hue < 0) hue += 6 * HUE_SIXTH;
      if (hue > 6 * HUE_SIXTH) hue -= 6 * HUE_SIXTH;
      res.hue = chan_t'(hue);
      res.sat = chan_t'(sat);
    end
    return res;
  endfunction

  // one pixel request, held until taken
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    hsl_expected.push_back(hsl_of_pixel(r, g, b));
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (hsl_expected.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input chan_t exp, input chan_t act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hsl_t exp;
    if (!rst && hsl_valid && !hsl_stall) begin
      if (hsl_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                 $time, hue_out, sat_out, light_out);
        mismatches++;
      end else begin
        exp = hsl_expected.pop_front();
        check_field("hue", exp.hue, hue_out);
        check_field("sat", exp.sat, sat_out);
        check_field("light", exp.light, light_out);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int pause;
    int held;
    int holds_done;
    holds_done = 0;
    hsl_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        hsl_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hsl_stall <= 1'b0;
      end else if (hsl_valid && !hsl_stall && stall_on) begin
        pause = $urandom_range(0, MAX_GAP);
        if (pause != 0) begin
          hsl_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          hsl_stall <= 1'b0;
        end
      end
    end
  end

  function automatic void random_pixel(output chan_t r, output chan_t g, output chan_t b);
    int    kind;
    int    base;
    chan_t top;
    chan_t other;
    kind = $urandom_range(0, 99);
    r = chan_t'($urandom);
    g = chan_t'($urandom);
    b = chan_t'($urandom);
    if (kind >= 50 && kind < 65) begin
      case ($urandom_range(0, 3))
        0:       top = '0;
        1:       top = chan_t'(CHAN_FULL);
        default: top = chan_t'($urandom);
      endcase
      r = top;
      g = top;
      b = top;
    end else if (kind >= 65 && kind < 80) begin
      top = ($urandom_range(0, 3) == 0) ? chan_t'(CHAN_FULL) : chan_t'($urandom_range(1, 255));
      other = chan_t'($urandom_range(0, top - 1));
      case ($urandom_range(0, 2))
        0:       begin r = top;   g = top;   b = other; end
        1:       begin r = top;   g = other; b = top;   end
        default: begin r = other; g = top;   b = top;   end
      endcase
    end else if (kind >= 80 && kind < 90) begin
      base = $urandom_range(0, 255);
      r = chan_t'((base + $urandom_range(0, 3) > 255) ? 255 : base + $urandom_range(0, 3));
      g = chan_t'((base - int'($urandom_range(0, 3)) < 0) ? 0 : base - $urandom_range(0, 3));
      b = chan_t'(base);
    end else if (kind >= 90) begin
      if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? chan_t'(CHAN_FULL) : '0;
      if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? chan_t'(CHAN_FULL) : '0;
      if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? chan_t'(CHAN_FULL) : '0;
    end
  endfunction

  task automatic test_corners();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd255, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd50, 8'd0);
    send_pixel(8'd255, 8'd1, 8'd128);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
  endtask

  // largest channel shared: red beats green and blue, green beats blue
  task automatic test_ties();
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd90, 8'd3, 8'd90);
    send_pixel(8'd1, 8'd77, 8'd77);
  endtask

  task automatic test_random_pixels(input int count);
    chan_t r, g, b;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 3))
          0:       begin sender_idle_on = 1'b0; stall_on = 1'b0; end
          1:       begin sender_idle_on = 1'b1; stall_on = 1'b0; end
          2:       begin sender_idle_on = 1'b0; stall_on = 1'b1; end
          default: begin sender_idle_on = 1'b1; stall_on = 1'b1; end
        endcase
      end
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // receiver holds off while requests keep coming, so the pipe fills
  task automatic test_output_hold();
    chan_t r, g, b;
    sender_idle_on = 1'b0;
    stall_on = 1'b0;
    hold_asks++;
    for (int i = 0; i < 40; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_drain_pause();
    chan_t r, g, b;
    sender_idle_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < 20; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    pix_valid <= 1'b0;
    red_in    <= '0;
    green_in  <= '0;
    blue_in   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_ties();
    test_random_pixels(900);
    test_output_hold();
    test_drain_pause();
    test_random_pixels(850);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && hsl_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ rgb_to_hsl_converter.f @@
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_div_step.sv
src/rhc_back.sv
src/rgb_to_hsl_converter.sv
src/rhc_checker.sv
tb/tb.sv
